### hw/rtl/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types and constants for the worker dispatch table.
// ----------------------------------------------------------------------------
package wdt_pkg;

  localparam int MAX_WORKERS_DEF = 16;

  // configuration register defaults and indexes
  localparam logic [15:0] MARGIN_RST  = 16'd50;
  localparam int          CFG_AW      = 2;
  localparam logic [CFG_AW-1:0] REG_MARGIN = '0;

  // request types
  localparam logic [1:0] REQ_GET    = 2'd0;
  localparam logic [1:0] REQ_REGET  = 2'd1;
  localparam logic [1:0] REQ_REG    = 2'd2;
  localparam logic [1:0] REQ_UPDATE = 2'd3;

  // acknowledge codes
  localparam logic [1:0] ACK_NONE    = 2'd0;
  localparam logic [1:0] ACK_OK      = 2'd1;
  localparam logic [1:0] ACK_ALLFAIL = 2'd2;
  localparam logic [1:0] ACK_FULL    = 2'd3;

  // entry status codes
  localparam logic [1:0] STAT_READY = 2'd0;
  localparam logic [1:0] STAT_OVL   = 2'd1;
  localparam logic [1:0] STAT_FAIL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_UPD_LEAST,
    ST_UPD_CHECK,
    ST_RESCAN,
    ST_RESCAN_END,
    ST_PICK_INIT,
    ST_PICK,
    ST_SEL,
    ST_OUT
  } wdt_state_t;

endpackage

### hw/rtl/wdt_in_if.sv
// ----------------------------------------------------------------------------
// wdt_in_if
// Request channel of the worker dispatch table.
// ----------------------------------------------------------------------------
interface wdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] worker_port;
  logic [31:0] worker_addr;
  logic        probe_failed;
  logic [3:0]  worker_index;
  logic [31:0] secret;
  logic [15:0] load_value;
  logic [31:0] new_secret;

  modport source (output valid, req_type, worker_port, worker_addr, probe_failed,
                  worker_index, secret, load_value, new_secret, input ready);
  modport sink (input valid, req_type, worker_port, worker_addr, probe_failed,
                worker_index, secret, load_value, new_secret, output ready);
endinterface

### hw/rtl/wdt_out_if.sv
// ----------------------------------------------------------------------------
// wdt_out_if
// Result channel of the worker dispatch table.
// ----------------------------------------------------------------------------
interface wdt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  ack;
  logic [15:0] sel_port;
  logic [31:0] sel_addr;
  logic [3:0]  out_index;
  logic [31:0] out_secret;

  modport source (output valid, ack, sel_port, sel_addr, out_index, out_secret,
                  input ready);
  modport sink (input valid, ack, sel_port, sel_addr, out_index, out_secret,
                output ready);
endinterface

### hw/rtl/wdt_cfg.sv
// ----------------------------------------------------------------------------
// wdt_cfg
// APB-style register file holding the overload margin.
// ----------------------------------------------------------------------------
module wdt_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wdt_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [15:0]                margin
);
  import wdt_pkg::*;

  logic [15:0] margin_r;

  assign pready = 1'b1;
  assign margin = margin_r;

  // margin register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RST;
    end else if (psel && penable && pwrite && paddr == REG_MARGIN) begin
      margin_r <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_MARGIN) begin
      prdata = {16'd0, margin_r};
    end
  end
endmodule

### hw/rtl/worker_dispatch_table.sv
// ----------------------------------------------------------------------------
// worker_dispatch_table
// Table of registered workers with round-robin and least-load selection.
//
//  channel  | dir | handshake        | carries
//  in_ch    | in  | valid/ready      | one request (get, reget, register, update)
//  out_ch   | out | valid/ready      | one result per request
//  cfg_*    | in  | APB write/read   | overload margin
//
// Every table scan walks one entry a cycle through the single table read port
// and its compare logic.
// Reset clears counters and pointers; table entries are not reset.
// in_ch.ready is high only while idle; a stalled result holds the block.
// ----------------------------------------------------------------------------
module worker_dispatch_table #(
  parameter int MAX_WORKERS = wdt_pkg::MAX_WORKERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wdt_in_if.sink                     in_ch,
  wdt_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [wdt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import wdt_pkg::*;

  localparam int IW = $clog2(MAX_WORKERS);
  localparam int CW = $clog2(MAX_WORKERS + 1);
  localparam int XW = CW + 4;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WORKERS);

  logic [15:0] margin;

  wdt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .margin  (margin)
  );

  // table storage
  logic [15:0] port_mem [MAX_WORKERS];
  logic [31:0] addr_mem [MAX_WORKERS];
  logic [1:0]  stat_mem [MAX_WORKERS];
  logic [15:0] load_mem [MAX_WORKERS];
  logic [31:0] sec_mem  [MAX_WORKERS];

  wdt_state_t  state_r, state_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] failed_r, failed_nxt;
  logic [IW-1:0] rr_r, rr_nxt;
  logic          rr_v_r, rr_v_nxt;
  logic [IW-1:0] least_r, least_nxt;
  logic [15:0]   lload_r, lload_nxt;

  // latched request
  logic [1:0]  req_r, req_nxt;
  logic [15:0] rport_r, rport_nxt;
  logic [31:0] raddr_r, raddr_nxt;
  logic [3:0]  ridx_r, ridx_nxt;
  logic [31:0] rsec_r, rsec_nxt;
  logic [15:0] rload_r, rload_nxt;
  logic [31:0] rnsec_r, rnsec_nxt;

  // result
  logic [1:0]  ack_r, ack_nxt;
  logic [15:0] selp_r, selp_nxt;
  logic [31:0] sela_r, sela_nxt;
  logic [3:0]  oidx_r, oidx_nxt;
  logic [31:0] osec_r, osec_nxt;

  // table read and write controls
  logic [IW-1:0] rd_idx;
  logic [15:0]   rd_port, rd_load;
  logic [31:0]   rd_addr, rd_sec;
  logic [1:0]    rd_stat;
  logic [IW-1:0] w_idx;
  logic          st_we, ld_we, new_we;
  logic [1:0]    st_wd;
  logic [15:0]   ld_wd;

  logic [CW-1:0] scan_idx_c, failed_inc, pos_inc, rr_inc;
  logic [IW-1:0] upd_idx;
  logic          upd_in_range, over_margin;

  assign upd_idx      = IW'(ridx_r);
  assign upd_in_range = XW'(ridx_r) < XW'(count_r);
  assign failed_inc   = failed_r + 1'b1;
  assign pos_inc      = CW'(pos_r) + 1'b1;
  assign rr_inc       = CW'(rr_r) + 1'b1;
  assign scan_idx_c   = scan_r;
  assign over_margin  = {1'b0, rload_r} > ({1'b0, lload_r} + {1'b0, margin});

  // single read port select
  always_comb begin
    unique case (state_r)
      ST_FIND, ST_RESCAN:          rd_idx = scan_idx_c[IW-1:0];
      ST_PICK:                     rd_idx = pos_r;
      ST_UPD_CHECK:                rd_idx = upd_idx;
      ST_SEL:                      rd_idx = rr_r;
      default:                     rd_idx = least_r;
    endcase
  end

  assign rd_port = port_mem[rd_idx];
  assign rd_addr = addr_mem[rd_idx];
  assign rd_stat = stat_mem[rd_idx];
  assign rd_load = load_mem[rd_idx];
  assign rd_sec  = sec_mem[rd_idx];

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = (state_r == ST_OUT);
  assign out_ch.ack       = ack_r;
  assign out_ch.sel_port  = selp_r;
  assign out_ch.sel_addr  = sela_r;
  assign out_ch.out_index = oidx_r;
  assign out_ch.out_secret = osec_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    rr_nxt     = rr_r;
    rr_v_nxt   = rr_v_r;
    least_nxt  = least_r;
    lload_nxt  = lload_r;
    req_nxt    = req_r;
    rport_nxt  = rport_r;
    raddr_nxt  = raddr_r;
    ridx_nxt   = ridx_r;
    rsec_nxt   = rsec_r;
    rload_nxt  = rload_r;
    rnsec_nxt  = rnsec_r;
    ack_nxt    = ack_r;
    selp_nxt   = selp_r;
    sela_nxt   = sela_r;
    oidx_nxt   = oidx_r;
    osec_nxt   = osec_r;
    w_idx      = rd_idx;
    st_we      = 1'b0;
    st_wd      = STAT_READY;
    ld_we      = 1'b0;
    ld_wd      = '0;
    new_we     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt   = in_ch.req_type;
          rport_nxt = in_ch.worker_port;
          raddr_nxt = in_ch.worker_addr;
          ridx_nxt  = in_ch.worker_index;
          rsec_nxt  = in_ch.secret;
          rload_nxt = in_ch.load_value;
          rnsec_nxt = in_ch.new_secret;
          ack_nxt   = ACK_NONE;
          selp_nxt  = '0;
          sela_nxt  = '0;
          oidx_nxt  = '0;
          osec_nxt  = '0;
          scan_nxt  = '0;
          unique case (in_ch.req_type)
            REQ_GET:    state_nxt = ST_PICK_INIT;
            REQ_REGET:  state_nxt = in_ch.probe_failed ? ST_FIND : ST_PICK_INIT;
            REQ_REG:    state_nxt = ST_FIND;
            REQ_UPDATE: state_nxt = ST_UPD_LEAST;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end

      // linear search by port and address
      ST_FIND: begin
        if (scan_r == count_r) begin
          if (req_r == REQ_REGET) begin
            state_nxt = ST_PICK_INIT;
          end else if (count_r < MAX_CNT) begin
            new_we    = 1'b1;
            st_we     = 1'b1;
            ld_we     = 1'b1;
            w_idx     = count_r[IW-1:0];
            ack_nxt   = ACK_OK;
            oidx_nxt  = 4'(count_r);
            osec_nxt  = rnsec_r;
            count_nxt = count_r + 1'b1;
            state_nxt = ST_OUT;
          end else begin
            ack_nxt   = ACK_FULL;
            state_nxt = ST_OUT;
          end
        end else if (rd_port == rport_r && rd_addr == raddr_r) begin
          if (req_r == REQ_REGET) begin
            state_nxt = ST_PICK_INIT;
            if (rd_stat != STAT_FAIL) begin
              st_we      = 1'b1;
              st_wd      = STAT_FAIL;
              failed_nxt = failed_inc;
              if (failed_inc < count_r && rd_idx == least_r) begin
                lload_nxt = rd_load;
                scan_nxt  = '0;
                state_nxt = ST_RESCAN;
              end
            end
          end else begin
            if (rd_stat == STAT_FAIL && failed_r != '0) begin
              failed_nxt = failed_r - 1'b1;
            end
            st_we     = 1'b1;
            ld_we     = 1'b1;
            ack_nxt   = ACK_OK;
            oidx_nxt  = 4'(scan_r);
            osec_nxt  = rd_sec;
            state_nxt = ST_OUT;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // fetch the least load before judging the update
      ST_UPD_LEAST: begin
        lload_nxt = rd_load;
        state_nxt = ST_UPD_CHECK;
      end

      ST_UPD_CHECK: begin
        state_nxt = ST_OUT;
        ack_nxt   = ACK_NONE;
        if (upd_in_range && rd_sec == rsec_r) begin
          ack_nxt = ACK_OK;
          st_we   = 1'b1;
          st_wd   = rd_stat;
          if (rd_stat == STAT_FAIL) begin
            st_wd = STAT_READY;
            if (failed_r != '0) begin
              failed_nxt = failed_r - 1'b1;
            end
          end
          ld_we = 1'b1;
          ld_wd = rload_r;
          if (upd_idx == least_r) begin
            if (rd_load < rload_r) begin
              lload_nxt = rload_r;
              scan_nxt  = '0;
              state_nxt = ST_RESCAN;
            end
          end else if (over_margin) begin
            st_wd = STAT_OVL;
          end else if (rload_r >= lload_r) begin
            st_wd = STAT_READY;
          end else begin
            least_nxt = upd_idx;
          end
        end
      end

      // walk the table for a lower live load
      ST_RESCAN: begin
        if (scan_r == count_r) begin
          state_nxt = ST_RESCAN_END;
        end else begin
          if (rd_load < lload_r && rd_stat != STAT_FAIL) begin
            least_nxt = scan_r[IW-1:0];
            lload_nxt = rd_load;
          end
          scan_nxt = scan_r + 1'b1;
        end
      end

      // the least loaded worker is revived
      ST_RESCAN_END: begin
        if (rd_stat == STAT_FAIL && failed_r != '0) begin
          failed_nxt = failed_r - 1'b1;
        end
        st_we     = 1'b1;
        state_nxt = (req_r == REQ_REGET) ? ST_PICK_INIT : ST_OUT;
      end

      ST_PICK_INIT: begin
        ack_nxt  = (failed_r < count_r) ? ACK_NONE : ACK_ALLFAIL;
        scan_nxt = '0;
        if (rr_v_r && rr_inc != count_r) begin
          pos_nxt = rr_inc[IW-1:0];
        end else begin
          pos_nxt = '0;
        end
        state_nxt = ST_PICK;
      end

      // round-robin search for a ready worker
      ST_PICK: begin
        if (scan_r == count_r) begin
          state_nxt = ST_SEL;
        end else if (rd_stat == STAT_READY) begin
          rr_nxt    = pos_r;
          rr_v_nxt  = 1'b1;
          ack_nxt   = ACK_OK;
          state_nxt = ST_SEL;
        end else begin
          scan_nxt = scan_r + 1'b1;
          pos_nxt  = (pos_inc == count_r) ? '0 : pos_inc[IW-1:0];
        end
      end

      ST_SEL: begin
        if (rr_v_r) begin
          selp_nxt = rd_port;
          sela_nxt = rd_addr;
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      failed_r <= '0;
      rr_v_r   <= 1'b0;
      rr_r     <= '0;
      least_r  <= '0;
      scan_r   <= '0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
      rr_v_r   <= rr_v_nxt;
      rr_r     <= rr_nxt;
      least_r  <= least_nxt;
      scan_r   <= scan_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lload_r <= lload_nxt;
    req_r   <= req_nxt;
    rport_r <= rport_nxt;
    raddr_r <= raddr_nxt;
    ridx_r  <= ridx_nxt;
    rsec_r  <= rsec_nxt;
    rload_r <= rload_nxt;
    rnsec_r <= rnsec_nxt;
    ack_r   <= ack_nxt;
    selp_r  <= selp_nxt;
    sela_r  <= sela_nxt;
    oidx_r  <= oidx_nxt;
    osec_r  <= osec_nxt;
  end

  // table writes
  always_ff @(posedge clk) begin
    if (st_we) begin
      stat_mem[w_idx] <= st_wd;
    end
    if (ld_we) begin
      load_mem[w_idx] <= ld_wd;
    end
    if (new_we) begin
      port_mem[w_idx] <= rport_r;
      addr_mem[w_idx] <= raddr_r;
      sec_mem[w_idx]  <= rnsec_r;
    end
  end

  // checks
  a_failed_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r <= count_r)
    else $error("failed count exceeds worker count");

  a_rr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    rr_v_r |-> (CW'(rr_r) < count_r))
    else $error("round-robin pointer beyond table");

  a_least_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (CW'(least_r) < count_r))
    else $error("least pointer beyond table");

  a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("worker count beyond capacity");

  a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> in_ch.ready)
    else $error("block not idle after result taken");

endmodule
